// ----- hw/rtl/binary_to_packed_bcd_top_macros.svh -----
// assertion macros for the binary to packed bcd converter
`ifndef BINARY_TO_PACKED_BCD_TOP_MACROS_SVH
`define BINARY_TO_PACKED_BCD_TOP_MACROS_SVH

`ifndef SYNTHESIS
// checked on every rising edge of clk once reset is released
`define B2BCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("b2bcd assertion failed");
// checked on every rising edge of clk, reset included
`define B2BCD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("b2bcd assertion failed");
`else
`define B2BCD_ASSERT(lbl, prop)
`define B2BCD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hw/rtl/b2bcd_pkg.sv -----
// shared types and constants of the binary to packed bcd converter
package b2bcd_pkg;

  localparam int VALUE_W = 16;
  localparam int BITCNT_W = 5;
  localparam int BYTECNT_W = 3;
  localparam int OUT_W = 32;
  localparam int NIB_W = 4;

  localparam logic [NIB_W-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [NIB_W-1:0] DIGIT_ADJ_ADD = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } b2bcd_state_t;

  // control fanned out from the sequencer to every digit cell
  typedef struct packed {
    logic clear;
    logic step;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/b2bcd_in_if.sv -----
// input channel: value, bit count and byte count
interface b2bcd_in_if;
  logic                               valid;
  logic                               ready;
  logic [b2bcd_pkg::VALUE_W-1:0]      binary_value;
  logic [b2bcd_pkg::BITCNT_W-1:0]     bit_count;
  logic [b2bcd_pkg::BYTECNT_W-1:0]    byte_count;

  modport source (output valid, output binary_value, output bit_count, output byte_count,
                  input ready);
  modport sink (input valid, input binary_value, input bit_count, input byte_count,
                output ready);
endinterface

// ----- hw/rtl/b2bcd_out_if.sv -----
// result channel: packed bcd digits
interface b2bcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [b2bcd_pkg::OUT_W-1:0]    packed_bcd;

  modport source (output valid, output packed_bcd, input ready);
  modport sink (input valid, input packed_bcd, output ready);
endinterface

// ----- hw/rtl/binary_to_packed_bcd_top.sv -----
// top level of the double-dabble binary to packed bcd converter
//
//  channel   direction  payload                                 transfer when
//  in_ch     in         binary_value, bit_count, byte_count     valid && ready
//  out_ch    out        packed_bcd                              valid && ready
//
// an item is handled in order: the digit chain is loaded, then one adjust-and-shift
// pass runs per source bit, N = min(bit_count, VALUE_BITS) passes in all, then the
// digits move into the output register. the pass count is set by the
// single bit counter that steps the whole chain one source bit per cycle.
// reset clears the sequencer and the output valid flag; digits clear on each load.
// the finished result waits in the output register, so a stalled sink only holds
// the chain once a second result is done and the register is still occupied.
`include "binary_to_packed_bcd_top_macros.svh"

module binary_to_packed_bcd_top #(
  parameter int VALUE_BITS = 16,
  parameter int BCD_BYTES  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  b2bcd_in_if.sink    in_ch,
  b2bcd_out_if.source out_ch
);

  localparam int NUM_DIGITS = 2 * BCD_BYTES;
  localparam int BCD_W      = NUM_DIGITS * b2bcd_pkg::NIB_W;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int IDX_W      = $clog2(VALUE_BITS);

  // sequencer state
  b2bcd_pkg::b2bcd_state_t state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        cnt_eff;
  logic [CNT_W-1:0]        cnt_m1;

  // source bits and active digit map, loaded at the input transfer
  logic [VALUE_BITS-1:0]   value_r, value_nxt;
  logic [NUM_DIGITS-1:0]   act_r, act_nxt;
  logic [NUM_DIGITS-1:0]   act_load;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [b2bcd_pkg::OUT_W-1:0] out_r, out_nxt;

  logic                    in_xfer;
  logic                    out_load;
  logic                    src_bit;
  b2bcd_pkg::cell_ctl_t    cell_ctl;

  // digit chain wiring
  logic [NUM_DIGITS:0]     chain;
  logic [BCD_W-1:0]        digits;
  logic [BCD_W-1:0]        act_nib_mask;

  assign in_xfer = in_ch.valid && in_ch.ready;

  // clamp the bit count to the source width
  always_comb begin
    if (int'(in_ch.bit_count) > VALUE_BITS) begin
      cnt_eff = CNT_W'(VALUE_BITS);
    end else begin
      cnt_eff = CNT_W'(in_ch.bit_count);
    end
  end

  // a digit is active when its byte is below the requested byte count
  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_act
    assign act_load[g] = int'(in_ch.byte_count) > (g / 2);
    assign act_nib_mask[g*b2bcd_pkg::NIB_W +: b2bcd_pkg::NIB_W] =
      {b2bcd_pkg::NIB_W{act_r[g]}};
  end

  // source bits go msb first, from bit cnt_r - 1 down to bit 0
  assign cnt_m1  = cnt_r - 1'b1;
  assign src_bit = value_r[cnt_m1[IDX_W-1:0]];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      b2bcd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (cnt_eff == '0) ? b2bcd_pkg::ST_FLUSH : b2bcd_pkg::ST_RUN;
        end
      end
      b2bcd_pkg::ST_RUN: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = b2bcd_pkg::ST_FLUSH;
        end
      end
      b2bcd_pkg::ST_FLUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = b2bcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = b2bcd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready    = 1'b0;
    cell_ctl.clear = 1'b0;
    cell_ctl.step  = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      b2bcd_pkg::ST_IDLE: begin
        in_ch.ready    = 1'b1;
        cell_ctl.clear = in_xfer;
      end
      b2bcd_pkg::ST_RUN: begin
        cell_ctl.step = 1'b1;
      end
      b2bcd_pkg::ST_FLUSH: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // counter, source and active map
  always_comb begin
    cnt_nxt   = cnt_r;
    value_nxt = value_r;
    act_nxt   = act_r;
    if (in_xfer) begin
      cnt_nxt   = cnt_eff;
      value_nxt = VALUE_BITS'(in_ch.binary_value);
      act_nxt   = act_load;
    end else if (cell_ctl.step) begin
      cnt_nxt = cnt_m1;
    end
  end

  // output register, takes the next result while the sink drains the old one
  always_comb begin
    out_nxt = out_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = b2bcd_pkg::OUT_W'(digits);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b2bcd_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    act_r   <= act_nxt;
    out_r   <= out_nxt;
  end

  // chain of digit cells, least significant digit takes the source bit
  assign chain[0] = src_bit;

  for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_cell
    b2bcd_digit_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .active    (act_r[d]),
      .shift_in  (chain[d]),
      .shift_out (chain[d+1]),
      .digit     (digits[d*b2bcd_pkg::NIB_W +: b2bcd_pkg::NIB_W])
    );
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.packed_bcd = out_r;

  // the chain only runs with source bits left
  `B2BCD_ASSERT(a_run_has_bits, (state_r == b2bcd_pkg::ST_RUN) |-> (cnt_r != '0))
  // an accepted item always leaves idle
  `B2BCD_ASSERT(a_xfer_leaves_idle, in_xfer |=> (state_r != b2bcd_pkg::ST_IDLE))
  // a result moved into the output register is offered the next cycle
  `B2BCD_ASSERT(a_load_shows_valid, out_load |=> out_ch.valid)
  // digits of inactive bytes never pick up a bit
  `B2BCD_ASSERT(a_inactive_zero,
    (state_r == b2bcd_pkg::ST_FLUSH) |-> ((digits & ~act_nib_mask) == '0))
  // input is never taken while a conversion is in flight
  `B2BCD_ASSERT_ALWAYS(a_ready_idle_only,
    in_ch.ready |-> (state_r == b2bcd_pkg::ST_IDLE))

endmodule

// ----- hw/rtl/b2bcd_digit_cell.sv -----
// one bcd digit of the double-dabble chain: adjust, then shift in from below
module b2bcd_digit_cell (
  input  logic                          clk,
  input  b2bcd_pkg::cell_ctl_t          ctl,
  input  logic                          active,
  input  logic                          shift_in,
  output logic                          shift_out,
  output logic [b2bcd_pkg::NIB_W-1:0]   digit
);

  logic [b2bcd_pkg::NIB_W-1:0] digit_r;
  logic [b2bcd_pkg::NIB_W-1:0] digit_nxt;
  logic [b2bcd_pkg::NIB_W-1:0] adj;

  // add 3 to digits of 5 or more, wraps within the nibble
  always_comb begin
    if (digit_r >= b2bcd_pkg::DIGIT_ADJ_MIN) begin
      adj = digit_r + b2bcd_pkg::DIGIT_ADJ_ADD;
    end else begin
      adj = digit_r;
    end
  end

  always_comb begin
    priority if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.step && active) begin
      digit_nxt = {adj[b2bcd_pkg::NIB_W-2:0], shift_in};
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  // an inactive cell passes nothing up, so bits leaving the top active digit are lost
  assign shift_out = active & adj[b2bcd_pkg::NIB_W-1];
  assign digit     = digit_r;

endmodule
